### sv/vmb_pkg.sv
package vmb_pkg;

  localparam int CODE_W   = 19;
  localparam int CORNER_W = 7;
  localparam int COLOR_W  = 8;
  localparam int DIR_W    = 3;

  // result kinds
  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_FACE   = 2'd1;
  localparam logic [1:0] KIND_CLOSE  = 2'd2;

  // face directions
  localparam logic [2:0] DIR_TOP     = 3'd0;
  localparam logic [2:0] DIR_BOTTOM  = 3'd1;
  localparam logic [2:0] DIR_PLUS_Z  = 3'd2;
  localparam logic [2:0] DIR_MINUS_Z = 3'd3;
  localparam logic [2:0] DIR_PLUS_X  = 3'd4;
  localparam logic [2:0] DIR_MINUS_X = 3'd5;

  // configuration register indexes
  localparam logic CFG_VERTEX_LIMIT = 1'b0;
  localparam logic CFG_FACE_LIMIT   = 1'b1;

  localparam logic [7:0] LIMIT_RESET      = 8'd128;
  localparam logic [7:0] VERTEX_LIMIT_MIN = 8'd4;
  localparam logic [7:0] FACE_LIMIT_MAX   = 8'd128;

  // emission steps of one item
  localparam logic [2:0] STEP_CLOSE   = 3'd0;
  localparam logic [2:0] STEP_CORNER0 = 3'd1;
  localparam logic [2:0] STEP_CORNER1 = 3'd2;
  localparam logic [2:0] STEP_CORNER2 = 3'd3;
  localparam logic [2:0] STEP_CORNER3 = 3'd4;
  localparam logic [2:0] STEP_FACE    = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAUNCH,
    S_SEARCH,
    S_DECIDE,
    S_EMIT
  } state_t;

  typedef logic [3:0][CODE_W-1:0] code_set_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [CODE_W-1:0]   vertex_code;
    logic [CORNER_W-1:0] corner_a;
    logic [CORNER_W-1:0] corner_b;
    logic [CORNER_W-1:0] corner_c;
    logic [CORNER_W-1:0] corner_d;
    logic [COLOR_W-1:0]  face_red;
    logic [COLOR_W-1:0]  face_green;
    logic [COLOR_W-1:0]  face_blue;
    logic [DIR_W-1:0]    orientation;
    logic [7:0]          face_total;
    logic                last;
  } result_t;

  function automatic logic [CODE_W-1:0] pack_vertex(input logic [4:0] x,
                                                     input logic [8:0] y,
                                                     input logic [4:0] z);
    return {y, z, x};
  endfunction

  // Four quad corners in emission order for one face.
  function automatic code_set_t make_codes(input logic [2:0] dir,
                                           input logic [3:0] x,
                                           input logic [7:0] y,
                                           input logic [3:0] z);
    logic [4:0]        bx;
    logic [8:0]        by;
    logic [4:0]        bz;
    logic              pos;
    logic [CODE_W-1:0] c1;
    logic [CODE_W-1:0] c2;
    logic [CODE_W-1:0] c3;
    code_set_t         r;
    pos = ~dir[0];
    bx  = {1'b0, x};
    by  = {1'b0, y};
    bz  = {1'b0, z};
    case (dir)
      DIR_TOP, DIR_BOTTOM: begin
        if (pos) by = by + 9'd1;
        c1 = pack_vertex(bx, by, bz + 5'd1);
        c2 = pack_vertex(bx + 5'd1, by, bz);
        c3 = pack_vertex(bx + 5'd1, by, bz + 5'd1);
      end
      DIR_PLUS_Z, DIR_MINUS_Z: begin
        if (pos) bz = bz + 5'd1;
        c1 = pack_vertex(bx + 5'd1, by, bz);
        c2 = pack_vertex(bx, by + 9'd1, bz);
        c3 = pack_vertex(bx + 5'd1, by + 9'd1, bz);
      end
      default: begin
        if (pos) bx = bx + 5'd1;
        c1 = pack_vertex(bx, by + 9'd1, bz);
        c2 = pack_vertex(bx, by, bz + 5'd1);
        c3 = pack_vertex(bx, by + 9'd1, bz + 5'd1);
      end
    endcase
    r[0] = pack_vertex(bx, by, bz);
    r[1] = pos ? c1 : c2;
    r[2] = pos ? c2 : c1;
    r[3] = c3;
    return r;
  endfunction

endpackage

### sv/vmb_in_if.sv
interface vmb_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [3:0] block_x;
  logic [7:0] block_y;
  logic [3:0] block_z;
  logic [2:0] face_dir;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (
    output valid, action, block_x, block_y, block_z, face_dir, red, green, blue,
    input  ready
  );

  modport sink (
    input  valid, action, block_x, block_y, block_z, face_dir, red, green, blue,
    output ready
  );
endinterface

### sv/vmb_out_if.sv
interface vmb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [18:0] vertex_code;
  logic [6:0]  corner_a;
  logic [6:0]  corner_b;
  logic [6:0]  corner_c;
  logic [6:0]  corner_d;
  logic [7:0]  face_red;
  logic [7:0]  face_green;
  logic [7:0]  face_blue;
  logic [2:0]  orientation;
  logic [7:0]  face_total;
  logic        last;

  modport source (
    output valid, kind, vertex_code, corner_a, corner_b, corner_c, corner_d,
           face_red, face_green, face_blue, orientation, face_total, last,
    input  ready
  );

  modport sink (
    input  valid, kind, vertex_code, corner_a, corner_b, corner_c, corner_d,
           face_red, face_green, face_blue, orientation, face_total, last,
    output ready
  );
endinterface

### sv/vmb_cell.sv
module vmb_cell #(
  parameter int CAP   = 128,
  parameter int INDEX = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  vmb_pkg::code_set_t            probe,
  input  logic [$clog2(CAP+1)-1:0]      count,
  input  logic                          start,
  input  logic                          wr_en,
  input  logic [$clog2(CAP)-1:0]        wr_idx,
  input  logic [vmb_pkg::CODE_W-1:0]    wr_code,
  input  logic                          tok_in,
  input  logic [3:0]                    hit_in,
  input  logic [3:0][$clog2(CAP)-1:0]   idx_in,
  output logic                          tok_out,
  output logic [3:0]                    hit_out,
  output logic [3:0][$clog2(CAP)-1:0]   idx_out
);

  localparam int CW = $clog2(CAP + 1);
  localparam int IW = $clog2(CAP);
  localparam logic [CW-1:0] HEAD_COUNT = CW'(INDEX + 1);
  localparam logic [IW-1:0] MY_INDEX   = IW'(INDEX);

  logic [vmb_pkg::CODE_W-1:0] code;
  logic                       tok;
  logic [3:0]                 hit;
  logic [3:0][IW-1:0]         idx;

  logic                       head;
  logic                       tok_next;
  logic [3:0]                 hit_next;
  logic [3:0][IW-1:0]         idx_next;

  // The topmost occupied cell starts the wave; others take it from above.
  always_comb begin
    head     = start && (count == HEAD_COUNT);
    tok_next = head | tok_in;
    hit_next = head ? '0 : hit_in;
    idx_next = head ? '0 : idx_in;
    for (int k = 0; k < 4; k++) begin
      if (!hit_next[k] && (code == probe[k])) begin
        hit_next[k] = 1'b1;
        idx_next[k] = MY_INDEX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else begin
      tok <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    hit <= hit_next;
    idx <= idx_next;
    if (wr_en && (wr_idx == MY_INDEX)) begin
      code <= wr_code;
    end
  end

  assign tok_out = tok;
  assign hit_out = hit;
  assign idx_out = idx;

endmodule

### sv/vmb_cell_row.sv
module vmb_cell_row #(
  parameter int CAP = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  vmb_pkg::code_set_t            probe,
  input  logic [$clog2(CAP+1)-1:0]      count,
  input  logic                          start,
  input  logic                          wr_en,
  input  logic [$clog2(CAP)-1:0]        wr_idx,
  input  logic [vmb_pkg::CODE_W-1:0]    wr_code,
  output logic                          done,
  output logic [3:0]                    hit,
  output logic [3:0][$clog2(CAP)-1:0]   idx
);

  localparam int IW = $clog2(CAP);

  logic [CAP:0]                tok_w;
  logic [CAP:0][3:0]           hit_w;
  logic [CAP:0][3:0][IW-1:0]   idx_w;

  // Nothing enters above the last cell.
  assign tok_w[CAP] = 1'b0;
  assign hit_w[CAP] = '0;
  assign idx_w[CAP] = '0;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    vmb_cell #(
      .CAP   (CAP),
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .probe   (probe),
      .count   (count),
      .start   (start),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_code (wr_code),
      .tok_in  (tok_w[i+1]),
      .hit_in  (hit_w[i+1]),
      .idx_in  (idx_w[i+1]),
      .tok_out (tok_w[i]),
      .hit_out (hit_w[i]),
      .idx_out (idx_w[i])
    );
  end

  assign done = tok_w[0];
  assign hit  = hit_w[0];
  assign idx  = idx_w[0];

endmodule

### sv/voxel_meshlet_builder.sv
// Channel  | Dir | Word                                   | Accepted when
// faces    | in  | action, block_x/y/z, face_dir, colour  | faces.valid & faces.ready
// results  | out | kind, vertex_code, corners, colour,    | results.valid & results.ready
//          |     | orientation, face_total, last          |
// config   | in  | write_index, write_data                | write_enable
//
// An add runs a lookup and then its emission steps (six steps, a step with no word
// is passed over without waiting for the output slot): the lookup wave walks once
// down the occupied vertex cells, one cell per cycle. An add into an empty meshlet
// skips the lookup and the close step; an end word emits a close word only when
// the meshlet holds faces.
// Reset is synchronous: counts clear and both limits return to 128; the vertex
// cells are not cleared, only entries below the vertex count are ever matched.
// A stalled result holds the step; faces.ready stays low until the last word
// of the item is loaded into the output register.
module voxel_meshlet_builder #(
  parameter int VERTEX_CAPACITY = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_enable,
  input  logic        write_index,
  input  logic [7:0]  write_data,
  vmb_in_if.sink      faces,
  vmb_out_if.source   results
);

  localparam int CW = $clog2(VERTEX_CAPACITY + 1);
  localparam int IW = $clog2(VERTEX_CAPACITY);
  // Sum width for vertex_count + need and the clamped limit.
  localparam int SW = ((CW > 8) ? CW : 8) + 2;

  vmb_pkg::state_t  state;
  vmb_pkg::state_t  state_next;

  // control registers
  logic [2:0]         step;
  logic [CW-1:0]      vcount;
  logic [7:0]         fcount;
  logic [7:0]         vlimit;
  logic [7:0]         flimit;
  logic               close_q;
  logic               end_item;
  logic [3:0]         hit_q;
  logic               out_valid;

  // payload registers
  vmb_pkg::code_set_t codes_q;
  logic [3:0][IW-1:0] idx_q;
  logic [7:0]         red_q;
  logic [7:0]         green_q;
  logic [7:0]         blue_q;
  logic [2:0]         dir_q;
  vmb_pkg::result_t   out_word;

  // cell row
  logic               row_done;
  logic [3:0]         row_hit;
  logic [3:0][IW-1:0] row_idx;
  logic               start;
  logic               wr_en;

  // combinational control
  logic               accept;
  logic               slot_free;
  logic               step_emits;
  logic               advance;
  logic               emit;
  logic [1:0]         corner;
  logic               over;
  logic [SW-1:0]      vlim;
  logic [8:0]         flim;
  logic [SW-1:0]      need;
  vmb_pkg::result_t   emit_word;

  vmb_cell_row #(
    .CAP (VERTEX_CAPACITY)
  ) u_row (
    .clk     (clk),
    .rst     (rst),
    .probe   (codes_q),
    .count   (vcount),
    .start   (start),
    .wr_en   (wr_en),
    .wr_idx  (vcount[IW-1:0]),
    .wr_code (codes_q[corner]),
    .done    (row_done),
    .hit     (row_hit),
    .idx     (row_idx)
  );

  // Saturate the limits and test whether the face fits the open meshlet.
  always_comb begin
    if (vlimit < vmb_pkg::VERTEX_LIMIT_MIN) begin
      vlim = SW'(vmb_pkg::VERTEX_LIMIT_MIN);
    end else if (SW'(vlimit) > SW'(VERTEX_CAPACITY)) begin
      vlim = SW'(VERTEX_CAPACITY);
    end else begin
      vlim = SW'(vlimit);
    end
    if (flimit == 8'd0) begin
      flim = 9'd1;
    end else if (flimit > vmb_pkg::FACE_LIMIT_MAX) begin
      flim = {1'b0, vmb_pkg::FACE_LIMIT_MAX};
    end else begin
      flim = {1'b0, flimit};
    end
    need = SW'(3'd4 - 3'($countones(hit_q)));
    over = ((SW'(vcount) + need) > vlim) || (({1'b0, fcount} + 9'd1) > flim);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      vmb_pkg::S_IDLE: begin
        if (faces.valid) begin
          if (faces.action) begin
            if (fcount != 8'd0) state_next = vmb_pkg::S_EMIT;
          end else if (faces.face_dir <= vmb_pkg::DIR_MINUS_X) begin
            state_next = (vcount == '0) ? vmb_pkg::S_EMIT : vmb_pkg::S_LAUNCH;
          end
        end
      end
      vmb_pkg::S_LAUNCH: state_next = vmb_pkg::S_SEARCH;
      vmb_pkg::S_SEARCH: begin
        if (row_done) state_next = vmb_pkg::S_DECIDE;
      end
      vmb_pkg::S_DECIDE: state_next = vmb_pkg::S_EMIT;
      vmb_pkg::S_EMIT: begin
        if (advance && ((step == vmb_pkg::STEP_FACE) ||
                        ((step == vmb_pkg::STEP_CLOSE) && end_item))) begin
          state_next = vmb_pkg::S_IDLE;
        end
      end
      default: state_next = vmb_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    faces.ready = (state == vmb_pkg::S_IDLE);
    accept      = faces.valid && faces.ready;
    start       = (state == vmb_pkg::S_LAUNCH);
    slot_free   = !out_valid || results.ready;
    corner      = 2'(step - vmb_pkg::STEP_CORNER0);

    case (step)
      vmb_pkg::STEP_CLOSE: step_emits = close_q;
      vmb_pkg::STEP_CORNER0, vmb_pkg::STEP_CORNER1,
      vmb_pkg::STEP_CORNER2, vmb_pkg::STEP_CORNER3: step_emits = !hit_q[corner];
      vmb_pkg::STEP_FACE: step_emits = 1'b1;
      default: step_emits = 1'b0;
    endcase

    // skip steps with no word at once, wait for the output slot otherwise
    advance = (state == vmb_pkg::S_EMIT) && (!step_emits || slot_free);
    emit    = advance && step_emits;
    wr_en   = emit && (step != vmb_pkg::STEP_CLOSE) && (step != vmb_pkg::STEP_FACE);

    emit_word = '0;
    case (step)
      vmb_pkg::STEP_CLOSE: begin
        emit_word.kind        = vmb_pkg::KIND_CLOSE;
        emit_word.vertex_code = vmb_pkg::CODE_W'(vcount);
        emit_word.face_total  = fcount;
        emit_word.last        = end_item;
      end
      vmb_pkg::STEP_FACE: begin
        emit_word.kind        = vmb_pkg::KIND_FACE;
        emit_word.corner_a    = vmb_pkg::CORNER_W'(idx_q[0]);
        emit_word.corner_b    = vmb_pkg::CORNER_W'(idx_q[1]);
        emit_word.corner_c    = vmb_pkg::CORNER_W'(idx_q[2]);
        emit_word.corner_d    = vmb_pkg::CORNER_W'(idx_q[3]);
        emit_word.face_red    = red_q;
        emit_word.face_green  = green_q;
        emit_word.face_blue   = blue_q;
        emit_word.orientation = dir_q;
        emit_word.last        = 1'b1;
      end
      default: begin
        emit_word.kind        = vmb_pkg::KIND_VERTEX;
        emit_word.vertex_code = codes_q[corner];
        emit_word.corner_a    = vmb_pkg::CORNER_W'(vcount);
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vmb_pkg::S_IDLE;
      step      <= vmb_pkg::STEP_CLOSE;
      vcount    <= '0;
      fcount    <= '0;
      vlimit    <= vmb_pkg::LIMIT_RESET;
      flimit    <= vmb_pkg::LIMIT_RESET;
      close_q   <= 1'b0;
      end_item  <= 1'b0;
      hit_q     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (write_enable) begin
        case (write_index)
          vmb_pkg::CFG_VERTEX_LIMIT: vlimit <= write_data;
          vmb_pkg::CFG_FACE_LIMIT:   flimit <= write_data;
          default: ;
        endcase
      end

      if (accept) begin
        end_item <= faces.action;
        close_q  <= faces.action;
        hit_q    <= '0;
        step     <= faces.action ? vmb_pkg::STEP_CLOSE : vmb_pkg::STEP_CORNER0;
      end

      // latch the wave result as it leaves cell zero
      if ((state == vmb_pkg::S_SEARCH) && row_done) begin
        hit_q <= row_hit;
      end

      // a close empties the table, so every corner becomes new
      if (state == vmb_pkg::S_DECIDE) begin
        close_q <= over;
        step    <= vmb_pkg::STEP_CLOSE;
        if (over) hit_q <= '0;
      end

      if (advance) begin
        step <= step + 3'd1;
      end

      if (emit) begin
        case (step)
          vmb_pkg::STEP_CLOSE: begin
            vcount <= '0;
            fcount <= '0;
          end
          vmb_pkg::STEP_FACE: fcount <= fcount + 8'd1;
          default: vcount <= vcount + CW'(1);
        endcase
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      codes_q <= vmb_pkg::make_codes(faces.face_dir, faces.block_x,
                                     faces.block_y, faces.block_z);
      red_q   <= faces.red;
      green_q <= faces.green;
      blue_q  <= faces.blue;
      dir_q   <= faces.face_dir;
    end
    if ((state == vmb_pkg::S_SEARCH) && row_done) begin
      idx_q <= row_idx;
    end
    if (wr_en) begin
      idx_q[corner] <= vcount[IW-1:0];
    end
    if (emit) begin
      out_word <= emit_word;
    end
  end

  assign results.valid       = out_valid;
  assign results.kind        = out_word.kind;
  assign results.vertex_code = out_word.vertex_code;
  assign results.corner_a    = out_word.corner_a;
  assign results.corner_b    = out_word.corner_b;
  assign results.corner_c    = out_word.corner_c;
  assign results.corner_d    = out_word.corner_d;
  assign results.face_red    = out_word.face_red;
  assign results.face_green  = out_word.face_green;
  assign results.face_blue   = out_word.face_blue;
  assign results.orientation = out_word.orientation;
  assign results.face_total  = out_word.face_total;
  assign results.last        = out_word.last;

endmodule

### sv/vmb_checker.sv
module vmb_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  res_kind,
  input logic [18:0] res_code,
  input logic [7:0]  res_face_total,
  input logic        res_last
);

  // output register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_code))
    else $error("stalled result word changed");

  // a face record always ends its item
  a_face_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_kind == vmb_pkg::KIND_FACE) |-> res_last)
    else $error("face record without last");

  // a new vertex word never ends its item; its face record follows
  a_vertex_not_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_kind == vmb_pkg::KIND_VERTEX) |-> !res_last)
    else $error("vertex word marked last");

  // only meshlets holding faces are closed
  a_close_nonempty: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_kind == vmb_pkg::KIND_CLOSE) |-> (res_face_total != 8'd0))
    else $error("empty meshlet closed");

endmodule

bind voxel_meshlet_builder vmb_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (results.valid),
  .res_ready      (results.ready),
  .res_kind       (results.kind),
  .res_code       (results.vertex_code),
  .res_face_total (results.face_total),
  .res_last       (results.last)
);
